>>> rtl/c8sx_pkg.sv
`default_nettype none
package c8sx_pkg;

    localparam int ROUND_COUNT = 8;
    // one half quarter-round step per cycle: two steps per round
    localparam int HALF_STEPS  = 2 * ROUND_COUNT;
    localparam int STEP_W      = $clog2(HALF_STEPS);

    localparam int DATA_W    = 64;
    localparam int BYTES_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 3;

    typedef logic [31:0] t_word;

    // "expand 32-byte k"
    localparam t_word SIGMA0 = 32'h61707865;
    localparam t_word SIGMA1 = 32'h3320646e;
    localparam t_word SIGMA2 = 32'h79622d32;
    localparam t_word SIGMA3 = 32'h6b206574;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

    typedef struct packed {
        logic              cap_in;
        logic              load;
        logic              round;
        logic [STEP_W-1:0] step;
        logic              feed;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic pos_zero;
    } t_stat;

    // keep low n bytes, n already clamped to 1..8
    function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (BYTES_W'(i) < n) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [BYTES_W-1:0] clamp_bytes(input logic [BYTES_W-1:0] n);
        logic [BYTES_W-1:0] r;
        r = n;
        if (n == '0) begin
            r = BYTES_W'(1);
        end else if (n > BYTES_W'(8)) begin
            r = BYTES_W'(8);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/chacha8_stream_xor.sv
`default_nettype none
// ChaCha8 stream XOR (64-bit nonce, 64-bit block counter). Message words of
// eight bytes come in on the input channel and leave XORed with the next
// eight keystream bytes, little-endian; bytes at and above o_out_bytes read
// zero, and a short word not marked last still uses a full keystream slot.
// The block counter starts at zero for each message and returns to zero after
// the word marked last. Feed zero data for plain keystream. Key and nonce are
// written through the config port (index 0..3 key, 4 nonce; others ignored);
// the user must write them only while no word is in flight, as the block
// itself does not enforce it. A word that opens a 64-byte block waits for
// the round engine: the state load, the round steps (one half quarter-round
// per cycle over all four columns or diagonals), the feed-forward and the
// output register. The single-entry input buffer takes no new word until the
// buffered one has been emitted, and an emit waits while the output register
// holds a stalled result. Output waiting in its register does not stop the
// next word from being taken into the input buffer.
module chacha8_stream_xor import c8sx_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // config write port
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [DATA_W-1:0]      i_cfg_data,
    // input words
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire [DATA_W-1:0]      i_msg_chunk,
    input  wire [BYTES_W-1:0]     i_chunk_bytes,
    input  wire                   i_msg_last,
    // result words
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [DATA_W-1:0]     o_out_chunk,
    output logic [BYTES_W-1:0]    o_out_bytes,
    output logic                  o_out_last
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: buffer/valid flags, round step count
    c8sx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // state words, round logic, key/nonce/counter, word registers
    c8sx_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_msg_chunk   (i_msg_chunk),
        .i_chunk_bytes (i_chunk_bytes),
        .i_msg_last    (i_msg_last),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_chunk   (o_out_chunk),
        .o_out_bytes   (o_out_bytes),
        .o_out_last    (o_out_last)
    );

endmodule
`default_nettype wire

>>> rtl/c8sx_ctrl.sv
`default_nettype none
module c8sx_ctrl import c8sx_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_out_stall,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FEED, S_EMIT} t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_in_full, n_in_full;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    always_comb begin
        out_free     = !r_out_valid || !i_out_stall;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        o_cmd.cap_in = i_in_valid && !r_in_full;
        n_state      = r_state;
        n_step       = r_step;
        case (r_state)
            S_IDLE: begin
                if (r_in_full) begin
                    if (i_stat.pos_zero) begin
                        o_cmd.load = 1'b1;
                        n_step     = '0;
                        n_state    = S_ROUND;
                    end else if (out_free) begin
                        o_cmd.emit = 1'b1;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_step == STEP_W'(HALF_STEPS - 1)) begin
                    n_state = S_FEED;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FEED: begin
                o_cmd.feed = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_in_full = r_in_full;
        if (o_cmd.emit) begin
            n_in_full = 1'b0;
        end else if (o_cmd.cap_in) begin
            n_in_full = 1'b1;
        end

        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_in_full   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_in_full   <= n_in_full;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_full;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> rtl/c8sx_datapath.sv
`default_nettype none
module c8sx_datapath import c8sx_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [DATA_W-1:0]      i_cfg_data,
    input  wire [DATA_W-1:0]      i_msg_chunk,
    input  wire [BYTES_W-1:0]     i_chunk_bytes,
    input  wire                   i_msg_last,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [DATA_W-1:0]     o_out_chunk,
    output logic [BYTES_W-1:0]    o_out_bytes,
    output logic                  o_out_last
);

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    function automatic t_word rotl(input t_word v, input int unsigned r);
        return (v << r) | (v >> (32 - r));
    endfunction

    // half of a quarter round: first half uses rotations 16/12, second 8/7
    function automatic t_quad qr_half(input t_word a, input t_word b, input t_word c,
                                      input t_word d, input logic ph);
        t_quad q;
        q.a = a + b;
        q.d = ph ? rotl(d ^ q.a, 8) : rotl(d ^ q.a, 16);
        q.c = c + q.d;
        q.b = ph ? rotl(b ^ q.c, 7) : rotl(b ^ q.c, 12);
        return q;
    endfunction

    logic [DATA_W-1:0]  r_key0, r_key1, r_key2, r_key3, r_nonce;
    logic [DATA_W-1:0]  r_cnt;
    logic [POS_W-1:0]   r_pos;
    t_word              r_w [16];
    t_word              n_w [16];
    t_word              init [16];
    logic [DATA_W-1:0]  r_msg;
    logic [BYTES_W-1:0] r_nbytes;
    logic               r_last;
    logic [DATA_W-1:0]  r_out_chunk;
    logic [BYTES_W-1:0] r_out_bytes;
    logic               r_out_last;
    logic [BYTES_W-1:0] nb;
    logic [DATA_W-1:0]  ks;

    always_comb begin
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        init[4]  = r_key0[31:0];
        init[5]  = r_key0[63:32];
        init[6]  = r_key1[31:0];
        init[7]  = r_key1[63:32];
        init[8]  = r_key2[31:0];
        init[9]  = r_key2[63:32];
        init[10] = r_key3[31:0];
        init[11] = r_key3[63:32];
        init[12] = r_cnt[31:0];
        init[13] = r_cnt[63:32];
        init[14] = r_nonce[31:0];
        init[15] = r_nonce[63:32];
    end

    // step bit 0: which half of the quarter round, bit 1: diagonal round
    always_comb begin
        t_quad q;
        q   = '0;
        n_w = r_w;
        if (i_cmd.load) begin
            n_w = init;
        end else if (i_cmd.round) begin
            for (int j = 0; j < 4; j++) begin
                if (!i_cmd.step[1]) begin
                    q = qr_half(r_w[j], r_w[4 + j], r_w[8 + j], r_w[12 + j],
                                i_cmd.step[0]);
                    n_w[j]      = q.a;
                    n_w[4 + j]  = q.b;
                    n_w[8 + j]  = q.c;
                    n_w[12 + j] = q.d;
                end else begin
                    q = qr_half(r_w[j], r_w[4 + ((j + 1) & 3)], r_w[8 + ((j + 2) & 3)],
                                r_w[12 + ((j + 3) & 3)], i_cmd.step[0]);
                    n_w[j]                 = q.a;
                    n_w[4 + ((j + 1) & 3)]  = q.b;
                    n_w[8 + ((j + 2) & 3)]  = q.c;
                    n_w[12 + ((j + 3) & 3)] = q.d;
                end
            end
        end else if (i_cmd.feed) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = r_w[i] + init[i];
            end
        end
    end

    assign nb = clamp_bytes(r_nbytes);
    assign ks = {r_w[{r_pos, 1'b1}], r_w[{r_pos, 1'b0}]};

    // control-side state: config, counter, chunk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0  <= '0;
            r_key1  <= '0;
            r_key2  <= '0;
            r_key3  <= '0;
            r_nonce <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY0:  r_key0  <= i_cfg_data;
                    CFG_KEY1:  r_key1  <= i_cfg_data;
                    CFG_KEY2:  r_key2  <= i_cfg_data;
                    CFG_KEY3:  r_key3  <= i_cfg_data;
                    CFG_NONCE: r_nonce <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.feed) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.emit && r_last) begin
                r_cnt <= '0;
            end
            if (i_cmd.emit) begin
                r_pos <= r_last ? '0 : r_pos + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (i_cmd.cap_in) begin
            r_msg    <= i_msg_chunk;
            r_nbytes <= i_chunk_bytes;
            r_last   <= i_msg_last;
        end
        if (i_cmd.emit) begin
            r_out_chunk <= (r_msg ^ ks) & byte_mask(nb);
            r_out_bytes <= nb;
            r_out_last  <= r_last;
        end
    end

    assign o_stat.pos_zero = (r_pos == '0);
    assign o_out_chunk     = r_out_chunk;
    assign o_out_bytes     = r_out_bytes;
    assign o_out_last      = r_out_last;

endmodule
`default_nettype wire

>>> rtl/c8sx_checker.sv
`default_nettype none
module c8sx_checker import c8sx_pkg::*; (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire [DATA_W-1:0]    o_out_chunk,
    input wire [BYTES_W-1:0]   o_out_bytes,
    input wire                 o_out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_chunk)
            && $stable(o_out_bytes) && $stable(o_out_last))
        else $error("result changed under stall");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("valid flags not cleared by reset");

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_bytes >= BYTES_W'(1) && o_out_bytes <= BYTES_W'(8))
        else $error("byte count out of range");

    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_chunk & ~byte_mask(o_out_bytes)) == '0)
        else $error("unused upper bytes not zero");

    // single-entry input buffer fills on every accept
    a_buf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input buffer did not fill");

endmodule

bind chacha8_stream_xor c8sx_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_chunk (o_out_chunk),
    .o_out_bytes (o_out_bytes),
    .o_out_last  (o_out_last)
);
`default_nettype wire
